// ----- design/seen_device_table_core_defines.svh -----
// ----------------------------------------------------------------------------
// Seen device table: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SEEN_DEVICE_TABLE_CORE_DEFINES_SVH
`define SEEN_DEVICE_TABLE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sdt_pkg.sv -----
// ----------------------------------------------------------------------------
// Seen device table package
// Field widths, status codes, register indexes and the table entry layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdt_pkg;

    // Default number of table entries.
    localparam int DEFAULT_TABLE_DEPTH = 64;

    // Fixed widths of the word fields.
    localparam int ADDR_W        = 48;
    localparam int RSSI_W        = 8;
    localparam int TIME_W        = 32;
    localparam int HITS_W        = 16;
    localparam int CATEGORY_W    = 8;
    localparam int STATUS_W      = 3;
    localparam int ENTRY_INDEX_W = 6;
    localparam int FILL_COUNT_W  = 7;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 8;

    typedef logic [STATUS_W-1:0]    status_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // Result status codes.
    localparam status_t ST_UNMATCHED = 3'd0;
    localparam status_t ST_FILTERED  = 3'd1;
    localparam status_t ST_WEAK      = 3'd2;
    localparam status_t ST_UPDATED   = 3'd3;
    localparam status_t ST_ADDED     = 3'd4;
    localparam status_t ST_FULL      = 3'd5;
    localparam status_t ST_CLEARED   = 3'd6;

    // Configuration register indexes.
    localparam cfg_index_t CFG_CATEGORY_MASK  = 2'd0;
    localparam cfg_index_t CFG_RSSI_THRESHOLD = 2'd1;

    // Register reset values.
    localparam logic [CATEGORY_W-1:0]    CATEGORY_MASK_RESET  = 8'hFF;
    localparam logic signed [RSSI_W-1:0] RSSI_THRESHOLD_RESET = -8'sd80;

    // Hit counter ceiling.
    localparam logic [HITS_W-1:0] HITS_MAX = '1;

    // One table entry as held in the memory.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [RSSI_W-1:0] rssi;
        logic [TIME_W-1:0] last_seen;
        logic [HITS_W-1:0] hits;
    } entry_t;

endpackage

// ----- design/seen_device_table_core.sv -----
// ----------------------------------------------------------------------------
// Seen device table core
// Filters classified advertisement reports and keeps a table of the device
// addresses seen, with their last RSSI, last-seen time and hit count.
// ----------------------------------------------------------------------------
//
// Channel  | Handshake              | Word
// ---------+------------------------+------------------------------------------
// command  | start, busy            | func, sig_found, sig_category, rssi,
//          |                        | device_addr, now_ms
// result   | result_valid (strobe)  | status, entry_index, hit_total, fill_count
// config   | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// A clear command or a report that fails a filter gives its result in the
// cycle after it is taken. A report that reaches the table is searched entry
// by entry until a hit or the end of the filled entries: the table lives in
// one synchronous memory, read one entry per cycle during the search, with
// the hit or the new entry written back in the final cycle. After reset the
// fill count alone marks the valid entries, so no clearing pass is needed.
// The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module seen_device_table_core #(
    parameter int TABLE_DEPTH = sdt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Command channel
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   func,
    input  logic                                   sig_found,
    input  logic [sdt_pkg::CATEGORY_W-1:0]         sig_category,
    input  logic signed [sdt_pkg::RSSI_W-1:0]      rssi,
    input  logic [sdt_pkg::ADDR_W-1:0]             device_addr,
    input  logic [sdt_pkg::TIME_W-1:0]             now_ms,
    // Configuration channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sdt_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [sdt_pkg::CFG_DATA_W-1:0]         cfg_data,
    // Result channel
    output logic                                   result_valid,
    output logic [sdt_pkg::STATUS_W-1:0]           status,
    output logic [sdt_pkg::ENTRY_INDEX_W-1:0]      entry_index,
    output logic [sdt_pkg::HITS_W-1:0]             hit_total,
    output logic [sdt_pkg::FILL_COUNT_W-1:0]       fill_count
);

    import sdt_pkg::*;

`include "seen_device_table_core_defines.svh"

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(TABLE_DEPTH);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t                     state_reg;
    logic [CATEGORY_W-1:0]      category_mask_reg;
    logic signed [RSSI_W-1:0]   rssi_threshold_reg;
    logic [FILL_W-1:0]          fill_reg;
    logic [FILL_W-1:0]          scan_idx_reg;
    logic                       cmp_valid_reg;
    logic [IDX_W-1:0]           cmp_idx_reg;
    logic [ADDR_W-1:0]          addr_reg;
    logic [RSSI_W-1:0]          rssi_in_reg;
    logic [TIME_W-1:0]          now_reg;

    logic                       result_valid_reg;
    status_t                    status_reg;
    logic [ENTRY_INDEX_W-1:0]   entry_index_reg;
    logic [HITS_W-1:0]          hit_total_reg;
    logic [FILL_COUNT_W-1:0]    fill_count_reg;

    // Table memory and its ports.
    entry_t                     table_mem [TABLE_DEPTH];
    entry_t                     mem_rdata;
    entry_t                     mem_wdata;
    logic                       mem_we;
    logic [IDX_W-1:0]           mem_waddr;

    logic                       accept;
    logic                       issue;
    logic                       hit;
    logic                       finish_miss;
    logic                       room;
    logic [HITS_W-1:0]          hits_next;
    logic [FILL_W-1:0]          fill_inc;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // Search control: one read issued per cycle, compared the cycle after.
    always_comb
    begin
        issue       = (state_reg == S_SCAN) && (scan_idx_reg < fill_reg);
        hit         = cmp_valid_reg && (mem_rdata.addr == addr_reg);
        finish_miss = !issue && !hit;
        room        = (fill_reg < DEPTH_FILL);
        fill_inc    = fill_reg + 1'b1;
        hits_next   = (mem_rdata.hits == HITS_MAX) ? mem_rdata.hits
                                                   : mem_rdata.hits + 1'b1;
    end

    // Write back on a hit, or append a new entry after a miss.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = fill_reg[IDX_W-1:0];
        mem_wdata.addr      = addr_reg;
        mem_wdata.rssi      = rssi_in_reg;
        mem_wdata.last_seen = now_reg;
        mem_wdata.hits      = HITS_W'(1);
        if (state_reg == S_SCAN)
        begin
            if (hit)
            begin
                mem_we         = 1'b1;
                mem_waddr      = cmp_idx_reg;
                mem_wdata.hits = hits_next;
            end
            else if (finish_miss && room)
            begin
                mem_we = 1'b1;
            end
        end
    end

    // Synchronous table memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (issue)
        begin
            mem_rdata <= table_mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            category_mask_reg  <= CATEGORY_MASK_RESET;
            rssi_threshold_reg <= RSSI_THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CATEGORY_MASK:  category_mask_reg  <= cfg_data;
                CFG_RSSI_THRESHOLD: rssi_threshold_reg <= $signed(cfg_data);
                default:            ;
            endcase
        end
    end

    // Control state machine and registered results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            fill_reg         <= '0;
            scan_idx_reg     <= '0;
            cmp_valid_reg    <= 1'b0;
            cmp_idx_reg      <= '0;
            addr_reg         <= '0;
            rssi_in_reg      <= '0;
            now_reg          <= '0;
            result_valid_reg <= 1'b0;
            status_reg       <= ST_UNMATCHED;
            entry_index_reg  <= '0;
            hit_total_reg    <= '0;
            fill_count_reg   <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        entry_index_reg <= '0;
                        hit_total_reg   <= '0;
                        fill_count_reg  <= func ? '0 : FILL_COUNT_W'(fill_reg);
                        priority if (func)
                        begin
                            fill_reg         <= '0;
                            status_reg       <= ST_CLEARED;
                            result_valid_reg <= 1'b1;
                        end
                        else if (!sig_found)
                        begin
                            status_reg       <= ST_UNMATCHED;
                            result_valid_reg <= 1'b1;
                        end
                        else if ((sig_category & category_mask_reg) == '0)
                        begin
                            status_reg       <= ST_FILTERED;
                            result_valid_reg <= 1'b1;
                        end
                        else if (rssi < rssi_threshold_reg)
                        begin
                            status_reg       <= ST_WEAK;
                            result_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            addr_reg      <= device_addr;
                            rssi_in_reg   <= rssi;
                            now_reg       <= now_ms;
                            scan_idx_reg  <= '0;
                            cmp_valid_reg <= 1'b0;
                            state_reg     <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    // A hit ends the search, so no compare is left pending.
                    cmp_valid_reg <= issue && !hit;
                    cmp_idx_reg   <= scan_idx_reg[IDX_W-1:0];
                    if (issue)
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                    priority if (hit)
                    begin
                        status_reg       <= ST_UPDATED;
                        entry_index_reg  <= ENTRY_INDEX_W'(cmp_idx_reg);
                        hit_total_reg    <= hits_next;
                        fill_count_reg   <= FILL_COUNT_W'(fill_reg);
                        result_valid_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                    else if (finish_miss)
                    begin
                        if (room)
                        begin
                            status_reg      <= ST_ADDED;
                            entry_index_reg <= ENTRY_INDEX_W'(fill_reg);
                            hit_total_reg   <= HITS_W'(1);
                            fill_count_reg  <= FILL_COUNT_W'(fill_inc);
                            fill_reg        <= fill_inc;
                        end
                        else
                        begin
                            status_reg      <= ST_FULL;
                            entry_index_reg <= '0;
                            hit_total_reg   <= '0;
                            fill_count_reg  <= FILL_COUNT_W'(fill_reg);
                        end
                        result_valid_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign entry_index  = entry_index_reg;
    assign hit_total    = hit_total_reg;
    assign fill_count   = fill_count_reg;

    // Checks on the table control.
    `SDT_ASSERT_SAME(a_fill_bounded, clk, rst_n, 1'b1, fill_reg <= DEPTH_FILL, "fill count beyond table depth")
    `SDT_ASSERT_NEXT(a_clear_result, clk, rst_n, accept && func, result_valid && (status == ST_CLEARED) && (fill_count == '0), "clear command did not give its result")
    `SDT_ASSERT_NEXT(a_unmatched_result, clk, rst_n, accept && !func && !sig_found, result_valid && (status == ST_UNMATCHED) && (fill_reg == $past(fill_reg)), "unmatched report altered the table")
    `SDT_ASSERT_SAME(a_added_hits, clk, rst_n, result_valid && (status == ST_ADDED), (hit_total == HITS_W'(1)) && (fill_count != '0), "new entry with a wrong hit count")

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seen device table core: self-checking testbench
// Drives advertisement reports and clear commands into the core, keeps its
// own copy of the address table to work out each result word, and compares
// every result word field by field. A short directed table comes first, then
// randomised phases under several filter settings, the last one on the reset
// settings with no idling.
// ----------------------------------------------------------------------------

module tb_top;

    import sdt_pkg::*;

    localparam int          DEPTH      = DEFAULT_TABLE_DEPTH;
    localparam int          DRAIN_WAIT = DEPTH + 16;
    localparam int unsigned CYCLE_CAP  = 3_000_000;
    localparam int          SHOW_MAX   = 10;

    // Register indexes that the core has no register behind.
    localparam cfg_index_t CFG_SPARE_LO = 2'd2;
    localparam cfg_index_t CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic                     func;
        logic                     found;
        logic [CATEGORY_W-1:0]    cat;
        logic signed [RSSI_W-1:0] rssi;
        logic [ADDR_W-1:0]        addr;
        logic [TIME_W-1:0]        now;
    } report_t;

    typedef struct packed {
        status_t                  status;
        logic [ENTRY_INDEX_W-1:0] slot;
        logic [HITS_W-1:0]        hits;
        logic [FILL_COUNT_W-1:0]  fill;
    } outcome_t;

    typedef struct packed {
        logic     fixed;
        report_t  rep;
        outcome_t out;
    } row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic                            func;
    logic                            sig_found;
    logic [CATEGORY_W-1:0]           sig_category;
    logic signed [RSSI_W-1:0]        rssi;
    logic [ADDR_W-1:0]               device_addr;
    logic [TIME_W-1:0]               now_ms;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [CFG_INDEX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]           cfg_data;
    logic                            result_valid;
    logic [STATUS_W-1:0]             status;
    logic [ENTRY_INDEX_W-1:0]        entry_index;
    logic [HITS_W-1:0]               hit_total;
    logic [FILL_COUNT_W-1:0]         fill_count;

    // Shadow of the core's table and filter registers.
    logic [ADDR_W-1:0]               seen_addr [DEPTH];
    logic [HITS_W-1:0]               seen_hits [DEPTH];
    int unsigned                     seen_fill;
    logic [CATEGORY_W-1:0]           filt_mask;
    logic signed [RSSI_W-1:0]        filt_floor;

    // Result words still owed by the core, oldest first.
    outcome_t                        owed_outcomes [$];

    // Typed expectation for the word currently on the command port.
    logic                            pin_fixed;
    outcome_t                        pin_outcome;

    row_t                            directed_rows [$];
    logic [ADDR_W-1:0]               addr_pool [$];
    int unsigned                     idle_pct;
    int unsigned                     mismatches;
    int unsigned                     checked;
    int unsigned                     cycles;
    int unsigned                     reg_writes;
    int unsigned                     status_seen [8];
    logic [HITS_W-1:0]               peak_hits;

    seen_device_table_core #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .sig_found    (sig_found),
        .sig_category (sig_category),
        .rssi         (rssi),
        .device_addr  (device_addr),
        .now_ms       (now_ms),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .status       (status),
        .entry_index  (entry_index),
        .hit_total    (hit_total),
        .fill_count   (fill_count)
    );

    initial clk = 1'b0;

    always #5 clk = ~clk;

    // Work out the result word of one accepted command and update the shadow.
    function automatic outcome_t track_report(report_t r);
        outcome_t o;
        int       hit_slot;
        o = '0;
        hit_slot = -1;
        if (r.func) begin
            seen_fill = 0;
            o.status = ST_CLEARED;
        end
        else if (!r.found) begin
            o.status = ST_UNMATCHED;
        end
        else if ((r.cat & filt_mask) == '0) begin
            o.status = ST_FILTERED;
        end
        else if ($signed(r.rssi) < $signed(filt_floor)) begin
            o.status = ST_WEAK;
        end
        else begin
            // The lowest valid slot holding the address wins.
            for (int i = 0; i < int'(seen_fill); i++) begin
                if (hit_slot < 0 && seen_addr[i] == r.addr) begin
                    hit_slot = i;
                end
            end
            if (hit_slot >= 0) begin
                if (seen_hits[hit_slot] != HITS_MAX) begin
                    seen_hits[hit_slot] = seen_hits[hit_slot] + 1'b1;
                end
                o.status = ST_UPDATED;
                o.slot   = hit_slot[ENTRY_INDEX_W-1:0];
                o.hits   = seen_hits[hit_slot];
            end
            else if (seen_fill < DEPTH) begin
                seen_addr[seen_fill] = r.addr;
                seen_hits[seen_fill] = HITS_W'(1);
                o.status  = ST_ADDED;
                o.slot    = seen_fill[ENTRY_INDEX_W-1:0];
                o.hits    = HITS_W'(1);
                seen_fill = seen_fill + 1;
            end
            else begin
                o.status = ST_FULL;
            end
        end
        o.fill = seen_fill[FILL_COUNT_W-1:0];
        return o;
    endfunction

    // Random command: mostly well-formed reports that reach the table, with
    // addresses drawn from a pool of recent ones so that hits are common.
    function automatic report_t rand_report(int unsigned new_pct, int unsigned clear_pm);
        report_t     r;
        int          floor_val;
        int unsigned pick;
        floor_val = $signed(filt_floor);
        r.func  = ($urandom_range(999) < clear_pm);
        r.found = ($urandom_range(99) < 90);
        pick = $urandom_range(9);
        if (pick < 5) begin
            r.cat = 8'h01 << $urandom_range(7);
        end
        else if (pick < 9) begin
            r.cat = CATEGORY_W'($urandom_range(255));
        end
        else begin
            r.cat = '0;
        end
        if ($urandom_range(99) < 75) begin
            r.rssi = RSSI_W'(floor_val + int'($urandom_range(127 - floor_val)));
        end
        else begin
            r.rssi = RSSI_W'($urandom_range(255));
        end
        if (addr_pool.size() == 0 || $urandom_range(99) < new_pct) begin
            r.addr = {16'($urandom_range(16'hFFFF)), $urandom()};
            addr_pool.push_back(r.addr);
            if (addr_pool.size() > 96) begin
                void'(addr_pool.pop_front());
            end
        end
        else begin
            r.addr = addr_pool[$urandom_range(addr_pool.size() - 1)];
            // Near miss: one bit away from a known address.
            if ($urandom_range(9) == 0) begin
                r.addr[$urandom_range(ADDR_W - 1)] ^= 1'b1;
            end
        end
        r.now = $urandom();
        return r;
    endfunction

    task automatic add_row(input logic func_v, input logic found_v,
                           input logic [CATEGORY_W-1:0] cat_v,
                           input logic signed [RSSI_W-1:0] rssi_v,
                           input logic [ADDR_W-1:0] addr_v,
                           input logic [TIME_W-1:0] now_v, input logic fixed_v,
                           input status_t st_v, input int slot_v, input int hits_v,
                           input int fill_v);
        row_t row;
        row.fixed      = fixed_v;
        row.rep.func   = func_v;
        row.rep.found  = found_v;
        row.rep.cat    = cat_v;
        row.rep.rssi   = rssi_v;
        row.rep.addr   = addr_v;
        row.rep.now    = now_v;
        row.out.status = st_v;
        row.out.slot   = ENTRY_INDEX_W'(slot_v);
        row.out.hits   = HITS_W'(hits_v);
        row.out.fill   = FILL_COUNT_W'(fill_v);
        directed_rows.push_back(row);
    endtask

    // Put one command word on the port, after an optional idle burst, and
    // hold it until the core takes it.
    task automatic send_report(input report_t r, input logic fixed, input outcome_t fo);
        int gap;
        gap = 0;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            gap = $urandom_range(3, 1);
        end
        if (gap != 0) begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        func         <= r.func;
        sig_found    <= r.found;
        sig_category <= r.cat;
        rssi         <= r.rssi;
        device_addr  <= r.addr;
        now_ms       <= r.now;
        start        <= 1'b1;
        pin_fixed   = fixed;
        pin_outcome = fo;
        do @(posedge clk); while (busy);
    endtask

    // Stop sending and wait until every owed result word has arrived.
    task automatic settle_idle();
        @(negedge clk);
        start <= 1'b0;
        while (owed_outcomes.size() != 0 || busy) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        reg_writes = reg_writes + 1;
    endtask

    // New filter settings, written with the core idle. The spare indexes get
    // junk that must leave both registers alone.
    task automatic set_filters(input logic [CATEGORY_W-1:0] mask,
                               input logic signed [RSSI_W-1:0] floor_v);
        settle_idle();
        write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom_range(255)));
        write_reg(CFG_CATEGORY_MASK, mask);
        write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom_range(255)));
        write_reg(CFG_RSSI_THRESHOLD, floor_v);
    endtask

    // Result checker, register shadow and command capture, all on one edge.
    always @(posedge clk) begin : watch_ports
        outcome_t want;
        report_t  taken;
        if (rst_n) begin
            if (result_valid) begin
                status_seen[status] = status_seen[status] + 1;
                if (hit_total > peak_hits) begin
                    peak_hits = hit_total;
                end
                if (owed_outcomes.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= SHOW_MAX) begin
                        $display("unexpected result word at cycle %0d: status %0d slot %0d",
                                 cycles, status, entry_index,
                                 " hits %0d fill %0d", hit_total, fill_count);
                    end
                end
                else begin
                    want = owed_outcomes.pop_front();
                    checked = checked + 1;
                    if (want.status !== status || want.slot !== entry_index ||
                        want.hits !== hit_total || want.fill !== fill_count) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= SHOW_MAX) begin
                            $display("mismatch on result %0d: expected status %0d slot %0d",
                                     checked, want.status, want.slot,
                                     " hits %0d fill %0d, got status %0d slot %0d",
                                     want.hits, want.fill, status, entry_index,
                                     " hits %0d fill %0d", hit_total, fill_count);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_CATEGORY_MASK) begin
                    filt_mask = cfg_data;
                end
                else if (cfg_index == CFG_RSSI_THRESHOLD) begin
                    filt_floor = cfg_data;
                end
            end
            if (start && !busy) begin
                taken.func  = func;
                taken.found = sig_found;
                taken.cat   = sig_category;
                taken.rssi  = rssi;
                taken.addr  = device_addr;
                taken.now   = now_ms;
                want = track_report(taken);
                owed_outcomes.push_back(pin_fixed ? pin_outcome : want);
            end
        end
    end

    always @(posedge clk) begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("timeout after %0d cycles with %0d result words owed",
                     cycles, owed_outcomes.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : drive_stimulus
        logic [CATEGORY_W-1:0] mask;
        logic signed [RSSI_W-1:0] floor_v;
        int unsigned      count;
        int unsigned      new_pct;
        int unsigned      clear_pm;

        // Everything known from time zero, with reset held low at the start.
        rst_n        = 1'b0;
        start        = 1'b0;
        func         = 1'b0;
        sig_found    = 1'b0;
        sig_category = '0;
        rssi         = '0;
        device_addr  = '0;
        now_ms       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        pin_fixed    = 1'b0;
        pin_outcome  = '0;
        seen_fill    = 0;
        filt_mask    = CATEGORY_MASK_RESET;
        filt_floor   = RSSI_THRESHOLD_RESET;
        idle_pct     = 30;
        mismatches   = 0;
        checked      = 0;
        cycles       = 0;
        reg_writes   = 0;
        peak_hits    = '0;
        foreach (status_seen[i]) status_seen[i] = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows under the reset filters: filter order, the threshold
        // edge, extreme addresses and times, clears, and a fresh table.
        add_row(0, 0, 8'hFF, 127, 48'h0, 32'h0, 1, ST_UNMATCHED, 0, 0, 0);
        add_row(0, 1, 8'h00, 127, 48'hFFFF_FFFF_FFFF, 32'h0, 1, ST_FILTERED, 0, 0, 0);
        add_row(0, 1, 8'hFF, -81, 48'h0, 32'h0, 1, ST_WEAK, 0, 0, 0);
        add_row(0, 0, 8'h00, -128, 48'h0, 32'h0, 1, ST_UNMATCHED, 0, 0, 0);
        add_row(0, 1, 8'h00, -128, 48'h0, 32'h0, 1, ST_FILTERED, 0, 0, 0);
        add_row(0, 1, 8'h01, -80, 48'h0, 32'h0, 1, ST_ADDED, 0, 1, 1);
        add_row(0, 1, 8'h80, 127, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1, ST_ADDED, 1, 1, 2);
        add_row(0, 1, 8'h10, 5, 48'h0, 32'h1234_5678, 1, ST_UPDATED, 0, 2, 2);
        add_row(0, 1, 8'h02, -1, 48'h1, 32'h0000_FFFF, 0, ST_UNMATCHED, 0, 0, 0);
        add_row(0, 1, 8'h40, -79, 48'hFFFF_FFFF_FFFF, 32'h8000_0000, 0, ST_UNMATCHED, 0, 0, 0);
        add_row(0, 1, 8'hFF, 0, 48'h8000_0000_0000, 32'h7FFF_FFFF, 0, ST_UNMATCHED, 0, 0, 0);
        add_row(1, 1, 8'hFF, 127, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1, ST_CLEARED, 0, 0, 0);
        add_row(1, 0, 8'h00, -128, 48'h0, 32'h0, 1, ST_CLEARED, 0, 0, 0);
        add_row(0, 1, 8'h04, -80, 48'h0, 32'h7, 1, ST_ADDED, 0, 1, 1);
        add_row(0, 0, 8'hFF, 127, 48'h0, 32'h8, 1, ST_UNMATCHED, 0, 0, 1);
        add_row(0, 1, 8'hFF, -128, 48'h0, 32'h9, 1, ST_WEAK, 0, 0, 1);
        add_row(0, 1, 8'h20, 0, 48'hA5A5_5A5A_C3C3, 32'hDEAD_BEEF, 0, ST_UNMATCHED, 0, 0, 0);
        add_row(0, 1, 8'h08, 100, 48'h0, 32'hCAFE_F00D, 0, ST_UNMATCHED, 0, 0, 0);
        foreach (directed_rows[i]) begin
            send_report(directed_rows[i].rep, directed_rows[i].fixed, directed_rows[i].out);
        end

        // Random phases, each under its own filter settings.
        for (int ph = 0; ph < 7; ph++) begin
            mask     = CATEGORY_W'($urandom_range(255));
            floor_v  = RSSI_W'($urandom_range(255));
            count    = 400;
            new_pct  = 40;
            clear_pm = 5;
            idle_pct = 30;
            case (ph)
                0: begin
                    // Wide open and mostly new addresses: runs the table full.
                    mask = 8'hFF; floor_v = -128; count = 300; new_pct = 80; clear_pm = 0;
                end
                1: begin
                    mask = 8'h00; floor_v = -80; count = 60;
                end
                2: begin
                    mask = 8'h01; floor_v = 127; count = 80; new_pct = 30;
                end
                3: begin
                    mask = 8'h80; floor_v = -80; count = 200; clear_pm = 10;
                end
                5: begin
                    new_pct = 50;
                end
                6: begin
                    // Closing stretch on the reset settings with no idling.
                    mask = CATEGORY_MASK_RESET; floor_v = RSSI_THRESHOLD_RESET;
                    count = 500; idle_pct = 0;
                end
                default: begin
                end
            endcase
            set_filters(mask, floor_v);
            for (int n = 0; n < int'(count); n++) begin
                if (idle_pct != 0 && $urandom_range(99) == 0) begin
                    settle_idle();
                end
                send_report(rand_report(new_pct, clear_pm), 1'b0, '0);
            end
        end

        settle_idle();
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("Checked %0d result words: %0d added, %0d updated, %0d full, %0d cleared,",
                 checked, status_seen[ST_ADDED], status_seen[ST_UPDATED],
                 status_seen[ST_FULL], status_seen[ST_CLEARED]);
        $display("%0d filtered out; peak hit count %0d; %0d register writes; %0d mismatches.",
                 status_seen[ST_UNMATCHED] + status_seen[ST_FILTERED]
                 + status_seen[ST_WEAK], peak_hits, reg_writes, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end
        else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/sdt_pkg.sv
design/seen_device_table_core.sv
tb/tb_top.sv
